// File: design/cpu8af_pkg.sv
// shared types, command codes and a helper function of the arithmetic flags unit
package cpu8af_pkg;

   localparam int unsigned CMD_W  = 4;
   localparam int unsigned BYTE_W = 8;
   localparam int unsigned WORD_W = 16;

   localparam logic [CMD_W-1:0] CMD_ADD      = 4'd0;
   localparam logic [CMD_W-1:0] CMD_ADC      = 4'd1;
   localparam logic [CMD_W-1:0] CMD_SUB      = 4'd2;
   localparam logic [CMD_W-1:0] CMD_SBB      = 4'd3;
   localparam logic [CMD_W-1:0] CMD_INR      = 4'd4;
   localparam logic [CMD_W-1:0] CMD_DCR      = 4'd5;
   localparam logic [CMD_W-1:0] CMD_DAA      = 4'd6;
   localparam logic [CMD_W-1:0] CMD_DAD      = 4'd7;
   localparam logic [CMD_W-1:0] CMD_INX      = 4'd8;
   localparam logic [CMD_W-1:0] CMD_DCX      = 4'd9;

   localparam logic [3:0]        NIBBLE_NINE = 4'd9;
   localparam logic [BYTE_W-1:0] DAA_LOW_FIX  = 8'h06;
   localparam logic [BYTE_W-1:0] DAA_HIGH_FIX = 8'h60;

   typedef struct packed {
      logic carry;
      logic aux;
      logic zero;
      logic sign;
      logic parity;
   } flags_type;

   typedef struct packed {
      logic [CMD_W-1:0]  command;
      logic [BYTE_W-1:0] operand_byte;
      logic [WORD_W-1:0] pair_value;
      logic [WORD_W-1:0] hl_value;
      logic              target_is_acc;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0] acc_out;
      logic [BYTE_W-1:0] byte_result;
      logic [WORD_W-1:0] word_result;
      flags_type         flags;
   } rsp_type;

   // zero, sign and even parity of a byte, other flags left clear
   function automatic flags_type zsp_of(input logic [BYTE_W-1:0] v);
      flags_type f;
      f        = '0;
      f.zero   = (v == '0);
      f.sign   = v[BYTE_W-1];
      f.parity = ~^v;
      return f;
   endfunction

endpackage

// File: design/cpu8af_req_if.sv
// request channel: command word with its operands
interface cpu8af_req_if;
   import cpu8af_pkg::*;

   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  command;
   logic [BYTE_W-1:0] operand_byte;
   logic [WORD_W-1:0] pair_value;
   logic [WORD_W-1:0] hl_value;
   logic              target_is_acc;

   modport source (output valid, command, operand_byte, pair_value, hl_value,
                   target_is_acc, input ready);
   modport sink   (input valid, command, operand_byte, pair_value, hl_value,
                   target_is_acc, output ready);
endinterface

// File: design/cpu8af_rsp_if.sv
// response channel: new accumulator, byte and word results, flags
interface cpu8af_rsp_if;
   import cpu8af_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] acc_out;
   logic [BYTE_W-1:0] byte_result;
   logic [WORD_W-1:0] word_result;
   logic              zero_out;
   logic              sign_out;
   logic              parity_out;
   logic              carry_out;
   logic              aux_carry_out;

   modport source (output valid, acc_out, byte_result, word_result, zero_out,
                   sign_out, parity_out, carry_out, aux_carry_out, input ready);
   modport sink   (input valid, acc_out, byte_result, word_result, zero_out,
                   sign_out, parity_out, carry_out, aux_carry_out, output ready);
endinterface

// File: design/cpu8af_alu.sv
// combinational arithmetic and flag logic for one command
module cpu8af_alu (
   input  cpu8af_pkg::req_type           req,
   input  logic [cpu8af_pkg::BYTE_W-1:0] acc,
   input  cpu8af_pkg::flags_type         flags,
   output cpu8af_pkg::rsp_type           rsp
);
   import cpu8af_pkg::*;

   logic              is_sub;
   logic              cin;
   logic [BYTE_W-1:0] addend;
   logic [BYTE_W:0]   sum9;
   logic [4:0]        half5;
   logic [BYTE_W-1:0] step_src;
   logic [BYTE_W-1:0] stepped;
   logic [3:0]        lo_nib;
   logic [3:0]        hi_nib;
   logic [BYTE_W-1:0] corr;
   logic              daa_carry;
   logic [BYTE_W-1:0] daa_res;
   logic [WORD_W:0]   wsum;

   always_comb begin
      // add and subtract share one adder, subtract inverts the operand
      is_sub = (req.command == CMD_SUB) || (req.command == CMD_SBB);
      case (req.command)
         CMD_ADC: cin = flags.carry;
         CMD_SUB: cin = 1'b1;
         CMD_SBB: cin = ~flags.carry;
         default: cin = 1'b0;
      endcase
      addend = is_sub ? ~req.operand_byte : req.operand_byte;
      sum9   = {1'b0, acc} + {1'b0, addend} + {{BYTE_W{1'b0}}, cin};
      half5  = {1'b0, acc[3:0]} + {1'b0, addend[3:0]} + {4'b0, cin};

      step_src = req.target_is_acc ? acc : req.operand_byte;
      stepped  = (req.command == CMD_INR) ? step_src + 8'd1 : step_src - 8'd1;

      lo_nib    = acc[3:0];
      hi_nib    = acc[7:4];
      corr      = '0;
      daa_carry = flags.carry;
      if (flags.aux || (lo_nib > NIBBLE_NINE)) begin
         corr = corr | DAA_LOW_FIX;
      end
      if (flags.carry || (hi_nib > NIBBLE_NINE) ||
          ((hi_nib == NIBBLE_NINE) && (lo_nib > NIBBLE_NINE))) begin
         corr      = corr | DAA_HIGH_FIX;
         daa_carry = 1'b1;
      end
      daa_res = acc + corr;

      wsum = {1'b0, req.hl_value} + {1'b0, req.pair_value};

      rsp.acc_out     = acc;
      rsp.byte_result = '0;
      rsp.word_result = '0;
      rsp.flags       = flags;

      case (req.command)
         CMD_ADD, CMD_ADC, CMD_SUB, CMD_SBB: begin
            rsp.acc_out     = sum9[BYTE_W-1:0];
            rsp.flags       = zsp_of(sum9[BYTE_W-1:0]);
            rsp.flags.carry = sum9[BYTE_W] ^ is_sub;
            rsp.flags.aux   = half5[4];
         end
         CMD_INR, CMD_DCR: begin
            rsp.byte_result = stepped;
            if (req.target_is_acc) begin
               rsp.acc_out = stepped;
            end
            rsp.flags       = zsp_of(stepped);
            rsp.flags.carry = flags.carry;
            rsp.flags.aux   = (req.command == CMD_INR) ? (stepped[3:0] == 4'd0)
                                                       : (step_src[3:0] != 4'd0);
         end
         CMD_DAA: begin
            rsp.acc_out     = daa_res;
            rsp.flags       = zsp_of(daa_res);
            rsp.flags.carry = daa_carry;
            rsp.flags.aux   = acc[4] ^ corr[4] ^ daa_res[4];
         end
         CMD_DAD: begin
            rsp.word_result = wsum[WORD_W-1:0];
            rsp.flags.carry = wsum[WORD_W];
         end
         CMD_INX: rsp.word_result = req.pair_value + 16'd1;
         CMD_DCX: rsp.word_result = req.pair_value - 16'd1;
         default: begin
         end
      endcase
   end

endmodule

// File: design/cpu8_arith_flags_unit.sv
// top level of the 8080-style arithmetic and flags unit
// an accepted word goes into the input register and then into the result register, which drives
// the response; throughput is one word per cycle while responses are taken; the accumulator
// and flags update as a word moves from the input register into the result register
// reset (synchronous, active high) clears the accumulator, all flags and both valids
module cpu8_arith_flags_unit (
   input logic          clock,
   input logic          reset,
   cpu8af_req_if.sink   req_ch,
   cpu8af_rsp_if.source rsp_ch
);
   import cpu8af_pkg::*;

   logic              in_valid_ff;
   logic              in_valid_in;
   req_type           in_data_ff;
   logic              out_valid_ff;
   logic              out_valid_in;
   rsp_type           out_data_ff;
   logic [BYTE_W-1:0] acc_ff;
   logic [BYTE_W-1:0] acc_in;
   flags_type         flags_ff;
   flags_type         flags_in;
   rsp_type           alu_rsp;
   logic              advance;
   logic              take_req;

   cpu8af_alu u_alu (
      .req   (in_data_ff),
      .acc   (acc_ff),
      .flags (flags_ff),
      .rsp   (alu_rsp)
   );

   // result register frees up when empty or being taken this cycle
   assign advance  = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign take_req = req_ch.valid && req_ch.ready;
   assign req_ch.ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in  = take_req ? 1'b1 : (in_valid_ff && !advance);
      out_valid_in = advance ? 1'b1 : (out_valid_ff && !rsp_ch.ready);
      acc_in       = advance ? alu_rsp.acc_out : acc_ff;
      flags_in     = advance ? alu_rsp.flags : flags_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         acc_ff       <= '0;
         flags_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         acc_ff       <= acc_in;
         flags_ff     <= flags_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take_req) begin
         in_data_ff.command       <= req_ch.command;
         in_data_ff.operand_byte  <= req_ch.operand_byte;
         in_data_ff.pair_value    <= req_ch.pair_value;
         in_data_ff.hl_value      <= req_ch.hl_value;
         in_data_ff.target_is_acc <= req_ch.target_is_acc;
      end
      if (advance) begin
         out_data_ff <= alu_rsp;
      end
   end

   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.acc_out       = out_data_ff.acc_out;
   assign rsp_ch.byte_result   = out_data_ff.byte_result;
   assign rsp_ch.word_result   = out_data_ff.word_result;
   assign rsp_ch.zero_out      = out_data_ff.flags.zero;
   assign rsp_ch.sign_out      = out_data_ff.flags.sign;
   assign rsp_ch.parity_out    = out_data_ff.flags.parity;
   assign rsp_ch.carry_out     = out_data_ff.flags.carry;
   assign rsp_ch.aux_carry_out = out_data_ff.flags.aux;

endmodule

// File: dv/testbench.sv
// self-checking testbench of the 8080-style arithmetic and flags unit
module testbench;
   import cpu8af_pkg::*;

   localparam logic [CMD_W-1:0] CMD_UNDEF_LO = 4'd10;
   localparam logic [CMD_W-1:0] CMD_UNDEF_HI = 4'd15;
   localparam int unsigned      RANDOM_WORDS = 1950;
   localparam int unsigned      MAX_WAIT     = 17;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic    req_valid = 1'b0;
   req_type req_word  = '0;
   logic    rsp_ready = 1'b0;

   cpu8af_req_if req_ch ();
   cpu8af_rsp_if rsp_ch ();

   assign req_ch.valid         = req_valid;
   assign req_ch.command       = req_word.command;
   assign req_ch.operand_byte  = req_word.operand_byte;
   assign req_ch.pair_value    = req_word.pair_value;
   assign req_ch.hl_value      = req_word.hl_value;
   assign req_ch.target_is_acc = req_word.target_is_acc;
   assign rsp_ch.ready         = rsp_ready;

   cpu8_arith_flags_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #10 clock = ~clock;

   req_type     instr_q[$];
   rsp_type     expected_rsp_q[$];
   int unsigned planned      = 0;
   int unsigned accepted     = 0;
   int unsigned checked      = 0;
   int unsigned errors       = 0;
   int unsigned cmd_seen[16];

   // architectural state of the predictor
   logic [BYTE_W-1:0] acc_model  = '0;
   flags_type         flag_model = '0;

   int unsigned send_gap   = 0;
   int unsigned send_run   = 0;
   bit          send_quiet = 1'b0;
   int unsigned recv_wait  = 0;
   int unsigned recv_run   = 0;
   bit          recv_quiet = 1'b0;

   function automatic flags_type byte_flags(input logic [BYTE_W-1:0] v);
      flags_type f;
      f        = '0;
      f.zero   = (v == 8'h00);
      f.sign   = v[7];
      f.parity = ~(v[0] ^ v[1] ^ v[2] ^ v[3] ^ v[4] ^ v[5] ^ v[6] ^ v[7]);
      return f;
   endfunction

   // wait before the next word; runs of words with no wait mix with runs of short or longer random waits
   function automatic int unsigned next_wait(inout int unsigned run_left, inout bit quiet);
      if (run_left == 0) begin
         quiet    = ($urandom_range(0, 2) == 0);
         run_left = $urandom_range(20, 80);
      end
      run_left--;
      if (quiet)
         return 0;
      return ($urandom_range(0, 3) == 0) ? $urandom_range(0, MAX_WAIT) : $urandom_range(0, 2);
   endfunction

   function automatic req_type make_word(input logic [CMD_W-1:0] cmd,
                                         input logic [BYTE_W-1:0] opb,
                                         input logic [WORD_W-1:0] pair,
                                         input logic [WORD_W-1:0] hl,
                                         input logic tgt);
      req_type w;
      w.command       = cmd;
      w.operand_byte  = opb;
      w.pair_value    = pair;
      w.hl_value      = hl;
      w.target_is_acc = tgt;
      return w;
   endfunction

   function automatic logic [WORD_W-1:0] random_pair();
      case ($urandom_range(0, 9))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return {$urandom_range(0, 1) ? 8'h80 : 8'h7F, $urandom_range(0, 1) ? 8'h00 : 8'hFF};
         default: return WORD_W'($urandom);
      endcase
   endfunction

   function automatic req_type random_word();
      req_type w;
      if ($urandom_range(0, 99) < 6)
         w.command = CMD_W'($urandom_range(CMD_UNDEF_LO, CMD_UNDEF_HI));
      else
         w.command = CMD_W'($urandom_range(CMD_ADD, CMD_DCX));
      case ($urandom_range(0, 11))
         0: w.operand_byte = 8'h00;
         1: w.operand_byte = 8'hFF;
         2: w.operand_byte = {$urandom_range(0, 1) ? 4'h0 : 4'hF, $urandom_range(0, 1) ? 4'h0 : 4'hF};
         3: w.operand_byte = {4'($urandom_range(8, 10)), 4'($urandom_range(8, 10))};
         default: w.operand_byte = BYTE_W'($urandom);
      endcase
      w.pair_value    = random_pair();
      // sometimes HL added to itself
      w.hl_value      = ($urandom_range(0, 9) == 0) ? w.pair_value : random_pair();
      w.target_is_acc = 1'($urandom_range(0, 1));
      return w;
   endfunction

   function automatic logic [BYTE_W-1:0] bcd_byte();
      return {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
   endfunction

   task automatic queue_word(input req_type w);
      instr_q.push_back(w);
      planned++;
   endtask

   // executes one accepted word on the predictor state and queues its result
   task automatic execute_instr(input req_type w);
      rsp_type           e;
      flags_type         f;
      logic [8:0]        sum9;
      logic [4:0]        half;
      logic [16:0]       sum17;
      logic [BYTE_W-1:0] operand;
      logic [BYTE_W-1:0] step_src;
      logic [BYTE_W-1:0] res;
      logic [BYTE_W-1:0] corr;
      logic [BYTE_W-1:0] mix;
      logic              cin;
      logic              is_sub;
      logic              new_carry;
      e = '0;
      case (w.command)
         CMD_ADD, CMD_ADC, CMD_SUB, CMD_SBB: begin
            is_sub  = (w.command == CMD_SUB) || (w.command == CMD_SBB);
            operand = is_sub ? ~w.operand_byte : w.operand_byte;
            case (w.command)
               CMD_ADD: cin = 1'b0;
               CMD_ADC: cin = flag_model.carry;
               CMD_SUB: cin = 1'b1;
               default: cin = ~flag_model.carry;
            endcase
            sum9  = {1'b0, acc_model} + {1'b0, operand} + {8'b0, cin};
            half  = {1'b0, acc_model[3:0]} + {1'b0, operand[3:0]} + {4'b0, cin};
            f       = byte_flags(sum9[7:0]);
            // subtract keeps borrow, the inverse of the adder carry
            f.carry = sum9[8] ^ is_sub;
            f.aux   = half[4];
            acc_model  = sum9[7:0];
            flag_model = f;
         end
         CMD_INR, CMD_DCR: begin
            step_src = w.target_is_acc ? acc_model : w.operand_byte;
            if (w.command == CMD_INR) begin
               res   = step_src + 8'h01;
               f     = byte_flags(res);
               f.aux = (res[3:0] == 4'h0);
            end else begin
               res   = step_src - 8'h01;
               f     = byte_flags(res);
               f.aux = (step_src[3:0] != 4'h0);
            end
            f.carry       = flag_model.carry;
            flag_model    = f;
            e.byte_result = res;
            if (w.target_is_acc)
               acc_model = res;
         end
         CMD_DAA: begin
            corr      = '0;
            new_carry = flag_model.carry;
            if (flag_model.aux || acc_model[3:0] > NIBBLE_NINE)
               corr = corr | DAA_LOW_FIX;
            if (flag_model.carry || acc_model[7:4] > NIBBLE_NINE ||
                (acc_model[7:4] >= NIBBLE_NINE && acc_model[3:0] > NIBBLE_NINE)) begin
               corr      = corr | DAA_HIGH_FIX;
               new_carry = 1'b1;
            end
            res     = acc_model + corr;
            mix     = acc_model ^ corr ^ res;
            f       = byte_flags(res);
            f.aux   = mix[4];
            f.carry = new_carry;
            acc_model  = res;
            flag_model = f;
         end
         CMD_DAD: begin
            sum17            = {1'b0, w.hl_value} + {1'b0, w.pair_value};
            e.word_result    = sum17[15:0];
            flag_model.carry = sum17[16];
         end
         CMD_INX: e.word_result = w.pair_value + 16'h0001;
         CMD_DCX: e.word_result = w.pair_value - 16'h0001;
         default: ;
      endcase
      e.acc_out = acc_model;
      e.flags   = flag_model;
      expected_rsp_q.push_back(e);
   endtask

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      $display("[%0t] result %0d: %s is %0h, expected %0h", $time, checked, what, got, want);
      errors++;
   endtask

   task automatic check_result();
      rsp_type want;
      if (expected_rsp_q.size() == 0) begin
         report_mismatch("unexpected word, acc_out", rsp_ch.acc_out, 0);
         return;
      end
      want = expected_rsp_q.pop_front();
      if (rsp_ch.acc_out !== want.acc_out)
         report_mismatch("acc_out", rsp_ch.acc_out, want.acc_out);
      if (rsp_ch.byte_result !== want.byte_result)
         report_mismatch("byte_result", rsp_ch.byte_result, want.byte_result);
      if (rsp_ch.word_result !== want.word_result)
         report_mismatch("word_result", rsp_ch.word_result, want.word_result);
      if (rsp_ch.zero_out !== want.flags.zero)
         report_mismatch("zero_out", rsp_ch.zero_out, want.flags.zero);
      if (rsp_ch.sign_out !== want.flags.sign)
         report_mismatch("sign_out", rsp_ch.sign_out, want.flags.sign);
      if (rsp_ch.parity_out !== want.flags.parity)
         report_mismatch("parity_out", rsp_ch.parity_out, want.flags.parity);
      if (rsp_ch.carry_out !== want.flags.carry)
         report_mismatch("carry_out", rsp_ch.carry_out, want.flags.carry);
      if (rsp_ch.aux_carry_out !== want.flags.aux)
         report_mismatch("aux_carry_out", rsp_ch.aux_carry_out, want.flags.aux);
      checked++;
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ch.ready) begin
            execute_instr(req_word);
            cmd_seen[req_word.command]++;
            accepted++;
         end
         if (!req_valid || req_ch.ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
               req_word  <= random_word();
            end else if (instr_q.size() > 0) begin
               req_valid <= 1'b1;
               req_word  <= instr_q.pop_front();
               send_gap  = next_wait(send_run, send_quiet);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ready) begin
            check_result();
            recv_wait = next_wait(recv_run, recv_quiet);
         end
         if (recv_wait > 0) begin
            recv_wait--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      int unsigned n_sub;
      int unsigned n_undef;
      // flag extremes of the byte adder
      queue_word(make_word(CMD_ADD, 8'h00, 16'h0000, 16'h0000, 1'b0));
      queue_word(make_word(CMD_ADD, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b1));
      queue_word(make_word(CMD_ADD, 8'h01, 16'h0000, 16'h0000, 1'b0));
      queue_word(make_word(CMD_ADC, 8'h7F, 16'h0000, 16'h0000, 1'b0));
      queue_word(make_word(CMD_SUB, 8'h01, 16'h0000, 16'h0000, 1'b0));
      queue_word(make_word(CMD_SUB, 8'h80, 16'h0000, 16'h0000, 1'b0));
      queue_word(make_word(CMD_SBB, 8'h00, 16'h0000, 16'h0000, 1'b0));
      queue_word(make_word(CMD_SBB, 8'hFF, 16'h0000, 16'h0000, 1'b0));
      // byte step on a register and on the accumulator, carry must hold
      queue_word(make_word(CMD_INR, 8'hFF, 16'h0000, 16'h0000, 1'b0));
      queue_word(make_word(CMD_INR, 8'h00, 16'h0000, 16'h0000, 1'b1));
      queue_word(make_word(CMD_DCR, 8'h00, 16'h0000, 16'h0000, 1'b0));
      queue_word(make_word(CMD_DCR, 8'h10, 16'h0000, 16'h0000, 1'b0));
      queue_word(make_word(CMD_DCR, 8'hFF, 16'h0000, 16'h0000, 1'b1));
      // decimal adjust after low and high nibble overflow
      queue_word(make_word(CMD_ADD, 8'h9A, 16'h0000, 16'h0000, 1'b0));
      queue_word(make_word(CMD_DAA, 8'h00, 16'h0000, 16'h0000, 1'b0));
      queue_word(make_word(CMD_ADD, 8'h99, 16'h0000, 16'h0000, 1'b0));
      queue_word(make_word(CMD_DAA, 8'hFF, 16'h0000, 16'h0000, 1'b0));
      // word add with carry out, zero, and HL added to itself
      queue_word(make_word(CMD_DAD, 8'h00, 16'h0001, 16'hFFFF, 1'b0));
      queue_word(make_word(CMD_DAD, 8'h00, 16'h0000, 16'h0000, 1'b0));
      queue_word(make_word(CMD_DAD, 8'h00, 16'h8000, 16'h8000, 1'b0));
      queue_word(make_word(CMD_INX, 8'h00, 16'hFFFF, 16'h0000, 1'b0));
      queue_word(make_word(CMD_DCX, 8'h00, 16'h0000, 16'h0000, 1'b0));
      queue_word(make_word(CMD_INX, 8'h00, 16'h7FFF, 16'h0000, 1'b0));
      // undefined codes leave the state alone
      queue_word(make_word(CMD_UNDEF_LO, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b1));
      queue_word(make_word(CMD_UNDEF_HI, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b1));

      while (planned < RANDOM_WORDS + 25) begin
         if ($urandom_range(0, 3) == 0) begin
            // decimal arithmetic: bcd add or subtract then adjust
            n_sub = $urandom_range(0, 3);
            queue_word(make_word(n_sub == 0 ? CMD_SUB : ($urandom_range(0, 1) ? CMD_ADC : CMD_ADD),
                                 bcd_byte(), random_pair(), random_pair(),
                                 1'($urandom_range(0, 1))));
            queue_word(make_word(CMD_DAA, BYTE_W'($urandom), random_pair(), random_pair(),
                                 1'($urandom_range(0, 1))));
         end else begin
            queue_word(random_word());
         end
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (accepted < planned || expected_rsp_q.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);

      n_undef = 0;
      for (int unsigned c = CMD_UNDEF_LO; c <= CMD_UNDEF_HI; c++)
         n_undef += cmd_seen[c];

      $display("%0d words sent, %0d results checked, %0d mismatches", accepted, checked, errors);
      $display("add/adc %0d, sub/sbb %0d, inr/dcr %0d, daa %0d, dad/inx/dcx %0d, undefined %0d",
               cmd_seen[CMD_ADD] + cmd_seen[CMD_ADC], cmd_seen[CMD_SUB] + cmd_seen[CMD_SBB],
               cmd_seen[CMD_INR] + cmd_seen[CMD_DCR], cmd_seen[CMD_DAA],
               cmd_seen[CMD_DAD] + cmd_seen[CMD_INX] + cmd_seen[CMD_DCX], n_undef);
      if (errors == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   initial begin
      #10_000_000;
      $display("timeout with %0d of %0d words accepted", accepted, planned);
      $display("== FAIL ==");
      $finish;
   end

endmodule
